/* sv/i2cstm_pkg.sv */
package i2cstm_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_ADDRESS    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_TIMEOUT_TICKS = 1'd1;

   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd45;
   localparam logic [15:0] ACK_TIMEOUT_RESET    = 16'd250;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PROBE = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } item_type;

endpackage

/* sv/i2cstm_if.sv */
interface i2cstm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] reg_addr;
   logic [7:0] wr_data;
   logic       sda_in;

   modport source (output valid, cmd, reg_addr, wr_data, sda_in, input ready);
   modport sink (input valid, cmd, reg_addr, wr_data, sda_in, output ready);
endinterface

interface i2cstm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_out;
   logic        sda_pull_low;
   logic        busy_res;
   logic        done_res;
   logic        failed;
   logic [1:0]  fail_stage;
   logic [15:0] raw_echo;
   logic [20:0] distance_mcm;

   modport source (output valid, scl_out, sda_pull_low, busy_res, done_res, failed,
                   fail_stage, raw_echo, distance_mcm, input ready);
   modport sink (input valid, scl_out, sda_pull_low, busy_res, done_res, failed,
                 fail_stage, raw_echo, distance_mcm, output ready);
endinterface

interface i2cstm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [i2cstm_pkg::CSR_INDEX_W-1:0] index;
   logic [i2cstm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/i2cstm_front.sv */
module i2cstm_front #(
   parameter int QUEUE_DEPTH = i2cstm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   i2cstm_req_if.sink           req_ch,
   output logic                 item_valid,
   input  logic                 item_ready,
   output i2cstm_pkg::item_type item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   i2cstm_pkg::item_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;
   i2cstm_pkg::item_type classified;

   // decode the incoming word into a command kind
   always_comb begin
      classified.reg_addr = req_ch.reg_addr;
      classified.wr_data  = req_ch.wr_data;
      classified.sda_in   = req_ch.sda_in;
      case (i2cstm_pkg::cmd_type'(req_ch.cmd))
         i2cstm_pkg::CMD_PROBE: classified.cmd = i2cstm_pkg::CMD_PROBE;
         i2cstm_pkg::CMD_WRITE: classified.cmd = i2cstm_pkg::CMD_WRITE;
         i2cstm_pkg::CMD_READ:  classified.cmd = i2cstm_pkg::CMD_READ;
         default:               classified.cmd = i2cstm_pkg::CMD_TICK;
      endcase
   end

   assign req_ch.ready = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign item_valid   = (count_ff != '0);
   assign pop          = item_valid && item_ready;
   assign item         = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* sv/i2cstm_back.sv */
module i2cstm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  i2cstm_pkg::item_type item,
   i2cstm_csr_if.sink           csr_ch,
   i2cstm_rsp_if.source         rsp_ch
);

   typedef enum logic [15:0] {
      PH_IDLE  = 16'h0001,
      PH_START = 16'h0002,
      PH_TXL   = 16'h0004,
      PH_TXH   = 16'h0008,
      PH_AKL   = 16'h0010,
      PH_AKH   = 16'h0020,
      PH_RXL   = 16'h0040,
      PH_RXH   = 16'h0080,
      PH_MAL   = 16'h0100,
      PH_MAH   = 16'h0200,
      PH_SPL   = 16'h0400,
      PH_SPH   = 16'h0800,
      PH_SPE   = 16'h1000,
      PH_FSL   = 16'h2000,
      PH_FSH   = 16'h4000,
      PH_FSE   = 16'h8000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [2:0]          bit_count_ff, bit_count_in;
   logic [7:0]          shift_byte_ff, shift_byte_in;
   logic [1:0]          byte_index_ff, byte_index_in;
   logic [15:0]         ack_wait_ff, ack_wait_in;
   logic [15:0]         read_buf_ff, read_buf_in;
   i2cstm_pkg::cmd_type kind_ff, kind_in;
   logic [7:0]          lat_reg_ff, lat_reg_in;
   logic [7:0]          lat_data_ff, lat_data_in;
   logic [6:0]          dev_addr_ff;
   logic [15:0]         timeout_ff;

   logic        rsp_valid_ff;
   logic        scl_ff, scl_in;
   logic        pull_ff, pull_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        fail_ff, fail_in;
   logic [1:0]  stage_ff, stage_in;
   logic [15:0] raw_ff, raw_in;
   logic [20:0] dist_ff, dist_in;

   logic        step;
   logic [16:0] poll_next;
   logic [1:0]  next_index;

   assign item_ready = !rsp_valid_ff || rsp_ch.ready;
   assign step       = item_valid && item_ready;
   assign poll_next  = {1'b0, ack_wait_ff} + 17'd1;
   assign next_index = byte_index_ff + 2'd1;

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_byte_in = shift_byte_ff;
      byte_index_in = byte_index_ff;
      ack_wait_in   = ack_wait_ff;
      read_buf_in   = read_buf_ff;
      kind_in       = kind_ff;
      lat_reg_in    = lat_reg_ff;
      lat_data_in   = lat_data_ff;
      scl_in        = 1'b1;
      pull_in       = 1'b0;
      busy_in       = 1'b1;
      done_in       = 1'b0;
      fail_in       = 1'b0;
      stage_in      = 2'd0;
      raw_in        = 16'd0;
      dist_in       = 21'd0;
      case (phase_ff)
         PH_IDLE: begin
            busy_in = 1'b0;
            if (item.cmd != i2cstm_pkg::CMD_TICK) begin
               kind_in       = item.cmd;
               lat_reg_in    = item.reg_addr;
               lat_data_in   = item.wr_data;
               byte_index_in = 2'd0;
               bit_count_in  = 3'd0;
               read_buf_in   = 16'd0;
               ack_wait_in   = 16'd0;
               shift_byte_in = {dev_addr_ff, (item.cmd == i2cstm_pkg::CMD_READ)};
               pull_in       = 1'b1;
               busy_in       = 1'b1;
               phase_in      = PH_START;
            end
         end
         PH_START: begin
            scl_in   = 1'b0;
            pull_in  = 1'b1;
            phase_in = PH_TXL;
         end
         PH_TXL: begin
            scl_in   = 1'b0;
            pull_in  = !shift_byte_ff[7];
            phase_in = PH_TXH;
         end
         PH_TXH: begin
            pull_in       = !shift_byte_ff[7];
            shift_byte_in = {shift_byte_ff[6:0], 1'b0};
            bit_count_in  = bit_count_ff + 3'd1;
            phase_in      = (bit_count_ff == 3'd7) ? PH_AKL : PH_TXL;
         end
         PH_AKL: begin
            scl_in      = 1'b0;
            ack_wait_in = 16'd0;
            phase_in    = PH_AKH;
         end
         PH_AKH: begin
            if (item.sda_in) begin
               if (poll_next > {1'b0, timeout_ff}) begin
                  phase_in = PH_FSL;
               end else begin
                  ack_wait_in = poll_next[15:0];
               end
            end else if (kind_ff == i2cstm_pkg::CMD_READ) begin
               bit_count_in = 3'd0;
               phase_in     = PH_RXL;
            end else if (kind_ff == i2cstm_pkg::CMD_WRITE && byte_index_ff < 2'd2) begin
               byte_index_in = next_index;
               shift_byte_in = (next_index == 2'd1) ? lat_reg_ff : lat_data_ff;
               phase_in      = PH_TXL;
            end else begin
               phase_in = PH_SPL;
            end
         end
         PH_RXL: begin
            scl_in   = 1'b0;
            phase_in = PH_RXH;
         end
         PH_RXH: begin
            read_buf_in  = {read_buf_ff[14:0], item.sda_in};
            bit_count_in = bit_count_ff + 3'd1;
            if (bit_count_ff == 3'd7) begin
               byte_index_in = next_index;
               phase_in      = PH_MAL;
            end else begin
               phase_in = PH_RXL;
            end
         end
         PH_MAL: begin
            scl_in   = 1'b0;
            pull_in  = (byte_index_ff == 2'd1);
            phase_in = PH_MAH;
         end
         PH_MAH: begin
            pull_in  = (byte_index_ff == 2'd1);
            phase_in = (byte_index_ff == 2'd1) ? PH_RXL : PH_SPL;
         end
         PH_SPL: begin
            scl_in   = 1'b0;
            pull_in  = 1'b1;
            phase_in = PH_SPH;
         end
         PH_FSL: begin
            scl_in   = 1'b0;
            pull_in  = 1'b1;
            phase_in = PH_FSH;
         end
         PH_SPH: begin
            pull_in  = 1'b1;
            phase_in = PH_SPE;
         end
         PH_FSH: begin
            pull_in  = 1'b1;
            phase_in = PH_FSE;
         end
         PH_SPE: begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (kind_ff == i2cstm_pkg::CMD_READ) begin
               raw_in  = read_buf_ff;
               // times 17 as times 16 plus one
               dist_in = {1'b0, read_buf_ff, 4'd0} + {5'd0, read_buf_ff};
            end
            phase_in = PH_IDLE;
         end
         PH_FSE: begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            fail_in  = 1'b1;
            stage_in = byte_index_ff;
            phase_in = PH_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cstm_pkg::DEVICE_ADDRESS_RESET;
         timeout_ff  <= i2cstm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            i2cstm_pkg::REG_DEVICE_ADDRESS:    dev_addr_ff <= csr_ch.data[6:0];
            i2cstm_pkg::REG_ACK_TIMEOUT_TICKS: timeout_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_byte_ff <= '0;
         byte_index_ff <= '0;
         ack_wait_ff   <= '0;
         read_buf_ff   <= '0;
         kind_ff       <= i2cstm_pkg::CMD_TICK;
         lat_reg_ff    <= '0;
         lat_data_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (step) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_byte_ff <= shift_byte_in;
            byte_index_ff <= byte_index_in;
            ack_wait_ff   <= ack_wait_in;
            read_buf_ff   <= read_buf_in;
            kind_ff       <= kind_in;
            lat_reg_ff    <= lat_reg_in;
            lat_data_ff   <= lat_data_in;
         end
         if (item_ready) begin
            rsp_valid_ff <= item_valid;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (step) begin
         scl_ff   <= scl_in;
         pull_ff  <= pull_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         fail_ff  <= fail_in;
         stage_ff <= stage_in;
         raw_ff   <= raw_in;
         dist_ff  <= dist_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_out      = scl_ff;
   assign rsp_ch.sda_pull_low = pull_ff;
   assign rsp_ch.busy_res     = busy_ff;
   assign rsp_ch.done_res     = done_ff;
   assign rsp_ch.failed       = fail_ff;
   assign rsp_ch.fail_stage   = stage_ff;
   assign rsp_ch.raw_echo     = raw_ff;
   assign rsp_ch.distance_mcm = dist_ff;

endmodule

/* sv/i2c_sensor_transaction_master.sv */
// a request word passes through the request queue, then its answer through the result word register
// throughput: one word per cycle while rsp_ch does not stall, set by the single bus-step state machine in the back end
// the request queue between front and back holds QUEUE_DEPTH words
// reset: synchronous, active high; bus idle, queue empty, address 45, ack timeout 250
module i2c_sensor_transaction_master #(
   parameter int QUEUE_DEPTH = i2cstm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   i2cstm_req_if.sink    req_ch,
   i2cstm_rsp_if.source  rsp_ch,
   i2cstm_csr_if.sink    csr_ch
);

   logic                 item_valid;
   logic                 item_ready;
   i2cstm_pkg::item_type item;

   i2cstm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   i2cstm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch)
   );

endmodule
